// ===== src/frltq_pkg.sv =====
// Shared constants, codes, result word type and address helpers for the transmit queue.
`timescale 1ns / 1ps

package frltq_pkg;

    localparam int PORTION_BYTES = 32;
    localparam int PORTION_COUNT = 8;

    localparam int SLOT_W = $clog2(PORTION_COUNT);
    localparam int POS_W  = $clog2(PORTION_BYTES + 1);
    localparam int ADDR_W = $clog2(PORTION_BYTES * PORTION_COUNT);
    localparam int STORE_DEPTH = PORTION_BYTES * PORTION_COUNT;

    localparam int PERIOD_W = 16;
    localparam int TIME_W   = 32;
    localparam int PROD_W   = POS_W + PERIOD_W;

    localparam logic [7:0]          FRAME_START       = 8'h24;
    localparam logic [PERIOD_W-1:0] BYTE_PERIOD_RESET = PERIOD_W'(1000000 / 3000);

    // input kinds
    localparam logic [1:0] KIND_FRAMED = 2'd0;
    localparam logic [1:0] KIND_RAW    = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // result kinds
    localparam logic OUT_BYTE   = 1'b0;
    localparam logic OUT_STATUS = 1'b1;

    // message status codes
    localparam logic [1:0] STAT_QUEUED  = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_TRUNC   = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } out_word_t;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] r;
        if (slot == SLOT_W'(PORTION_COUNT - 1))
            r = '0;
        else
            r = slot + SLOT_W'(1);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [POS_W-1:0]  pos);
        logic [ADDR_W-1:0] r;
        r = ADDR_W'(slot) * ADDR_W'(PORTION_BYTES) + ADDR_W'(pos);
        return r;
    endfunction

endpackage

// ===== src/frltq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module frltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== src/framed_rate_limited_tx_queue_top.sv =====
// Top level of the framed, rate-limited transmit queue.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser=kind, tlast=last_byte,
//          |     |                    | tdata={time_us[39:8], data_byte[7:0]}
//  m_*     | out | m_tvalid/m_tready  | tuser=out_kind, tlast=out_last,
//          |     |                    | tdata={6'b0, out_status[9:8], out_byte[7:0]}
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data=byte_period_us (always ready)
//
// Sequence: one item at a time. A message byte is accepted, then written to the store (the
// first byte of a framed message first writes the '$' on its own); the last byte adds a
// closing step for the checksum write and the status word. A tick that is not due returns
// to idle after decode; a due tick steps through accept, length lookup, multiply, add,
// one store read per byte, and a closing step that retires the slot. The single write
// port of the portion store and its registered read data set this sequence.
// Reset: control state clears at once; store contents stay undefined (only committed
// slots are read). Stalls: a 2-word output buffer decouples m_tready; byte reads are
// issued only when a buffer slot is guaranteed, so output backpressure just slows
// the emit loop.
`timescale 1ns / 1ps

module framed_rate_limited_tx_queue_top
    import frltq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] time_us
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic        s_tlast,   // last_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] out_status, [15:10] zero
    output logic [0:0]  m_tuser,   // [0] out_kind
    output logic        m_tlast,   // out_last
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // byte_period_us
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROC  = 3'd1;  // message byte or tick decode
    localparam logic [2:0] ST_CLOSE = 3'd2;  // checksum, commit, status word
    localparam logic [2:0] ST_TLEN  = 3'd3;  // length back from RAM, multiply
    localparam logic [2:0] ST_TNEXT = 3'd4;  // next send time
    localparam logic [2:0] ST_EMIT  = 3'd5;  // stream portion bytes

    logic [2:0] state_reg, state_next;

    // latched input word
    logic [1:0]        item_kind_reg;
    logic [7:0]        item_data_reg;
    logic              item_last_reg;
    logic [TIME_W-1:0] item_time_reg;

    // queue and fill state
    logic [SLOT_W-1:0]   rslot_reg, rslot_next;
    logic [SLOT_W-1:0]   wslot_reg, wslot_next;
    logic [TIME_W-1:0]   nst_reg, nst_next;
    logic [POS_W-1:0]    fill_reg, fill_next;
    logic [7:0]          sum_reg, sum_next;
    logic                trunc_reg, trunc_next;
    logic                framed_reg, framed_next;
    logic [PERIOD_W-1:0] period_reg, period_next;

    // emit loop
    logic [POS_W-1:0]  len_reg, len_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [POS_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;           // store read in flight
    logic              pend_last_reg, pend_last_next;

    // RAM ports
    logic              store_we, store_re;
    logic [ADDR_W-1:0] store_waddr, store_raddr;
    logic [7:0]        store_wdata, store_rdata;
    logic              len_we, len_re;
    logic [SLOT_W-1:0] len_waddr, len_raddr;
    logic [POS_W-1:0]  len_wdata, len_rdata;

    // output buffer, 2 words
    out_word_t  obuf_reg [2];
    logic       obuf_wptr_reg, obuf_wptr_next;
    logic       obuf_rptr_reg, obuf_rptr_next;
    logic [1:0] obuf_cnt_reg, obuf_cnt_next;
    logic       push, pop;
    out_word_t  push_word;
    out_word_t  head_word;
    logic [2:0] occ;
    logic       space;

    // message byte helpers
    logic              msg_start;
    logic              eff_framed;
    logic [7:0]        eff_sum;
    logic              eff_trunc;
    logic [POS_W-1:0]  fill_limit;
    logic [POS_W-1:0]  close_len;
    logic              ring_full;

    frltq_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (store_wdata),
        .rd_en   (store_re),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

    frltq_ram #(
        .WIDTH (POS_W),
        .DEPTH (PORTION_COUNT)
    ) u_len (
        .clk     (clk),
        .wr_en   (len_we),
        .wr_addr (len_waddr),
        .wr_data (len_wdata),
        .rd_en   (len_re),
        .rd_addr (len_raddr),
        .rd_data (len_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // output side
    assign head_word = obuf_reg[obuf_rptr_reg];
    assign m_tvalid  = (obuf_cnt_reg != 2'd0);
    assign m_tdata   = {6'b0, head_word.status, head_word.data};
    assign m_tuser   = head_word.kind;
    assign m_tlast   = head_word.last;
    assign pop       = m_tvalid & m_tready;

    // words held after this edge, counting a read landing this cycle
    assign occ   = {1'b0, obuf_cnt_reg} + {2'b0, pend_reg} - {2'b0, pop};
    assign space = (occ < 3'd2);

    // effective fill context: a new message starts at position zero
    assign msg_start  = (fill_reg == '0);
    assign eff_framed = msg_start ? (item_kind_reg == KIND_FRAMED) : framed_reg;
    assign eff_sum    = msg_start ? 8'd0 : sum_reg;
    assign eff_trunc  = msg_start ? 1'b0 : trunc_reg;
    assign fill_limit = eff_framed ? POS_W'(PORTION_BYTES - 1) : POS_W'(PORTION_BYTES);
    assign close_len  = framed_reg ? fill_reg + POS_W'(1) : fill_reg;
    assign ring_full  = (slot_inc(wslot_reg) == rslot_reg);

    always_comb
    begin
        state_next     = state_reg;
        rslot_next     = rslot_reg;
        wslot_next     = wslot_reg;
        nst_next       = nst_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        trunc_next     = trunc_reg;
        framed_next    = framed_reg;
        period_next    = period_reg;
        len_next       = len_reg;
        prod_next      = prod_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;

        store_we    = 1'b0;
        store_waddr = '0;
        store_wdata = '0;
        store_re    = 1'b0;
        store_raddr = '0;
        len_we      = 1'b0;
        len_waddr   = '0;
        len_wdata   = '0;
        len_re      = 1'b0;
        len_raddr   = '0;

        push      = 1'b0;
        push_word = '0;

        if (cfg_valid)
        begin
            period_next = cfg_data;
        end

        // a store read issued last cycle lands in the buffer now
        if (pend_reg)
        begin
            push           = 1'b1;
            push_word.kind = OUT_BYTE;
            push_word.data = store_rdata;
            push_word.last = pend_last_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PROC;
                end
            end

            ST_PROC:
            begin
                case (item_kind_reg)
                    KIND_TICK:
                    begin
                        if ((rslot_reg != wslot_reg) && (item_time_reg > nst_reg))
                        begin
                            len_re     = 1'b1;
                            len_raddr  = rslot_reg;
                            state_next = ST_TLEN;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end

                    KIND_FRAMED, KIND_RAW:
                    begin
                        if (msg_start && (item_kind_reg == KIND_FRAMED))
                        begin
                            // frame start marker, data byte follows next cycle
                            store_we    = 1'b1;
                            store_waddr = store_addr(wslot_reg, '0);
                            store_wdata = FRAME_START;
                            fill_next   = POS_W'(1);
                            framed_next = 1'b1;
                            sum_next    = 8'd0;
                            trunc_next  = 1'b0;
                        end
                        else
                        begin
                            framed_next = eff_framed;
                            if (fill_reg < fill_limit)
                            begin
                                store_we    = 1'b1;
                                store_waddr = store_addr(wslot_reg, fill_reg);
                                store_wdata = item_data_reg;
                                sum_next    = eff_sum + item_data_reg;
                                fill_next   = fill_reg + POS_W'(1);
                                trunc_next  = eff_trunc;
                            end
                            else
                            begin
                                sum_next   = eff_sum;
                                trunc_next = 1'b1;
                            end
                            state_next = item_last_reg ? ST_CLOSE : ST_IDLE;
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_CLOSE:
            begin
                if (!pend_reg && space)
                begin
                    if (framed_reg)
                    begin
                        store_we    = 1'b1;
                        store_waddr = store_addr(wslot_reg, fill_reg);
                        store_wdata = sum_reg;
                    end
                    push           = 1'b1;
                    push_word.kind = OUT_STATUS;
                    if (ring_full)
                    begin
                        push_word.status = STAT_DROPPED;
                    end
                    else
                    begin
                        len_we           = 1'b1;
                        len_waddr        = wslot_reg;
                        len_wdata        = close_len;
                        wslot_next       = slot_inc(wslot_reg);
                        push_word.status = trunc_reg ? STAT_TRUNC : STAT_QUEUED;
                    end
                    fill_next   = '0;
                    sum_next    = 8'd0;
                    trunc_next  = 1'b0;
                    framed_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end

            ST_TLEN:
            begin
                len_next   = len_rdata;
                prod_next  = PROD_W'(len_rdata) * PROD_W'(period_reg);
                state_next = ST_TNEXT;
            end

            ST_TNEXT:
            begin
                nst_next   = item_time_reg + TIME_W'(prod_reg);
                idx_next   = '0;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (idx_reg == len_reg)
                begin
                    rslot_next = slot_inc(rslot_reg);
                    state_next = ST_IDLE;
                end
                else if (space)
                begin
                    store_re       = 1'b1;
                    store_raddr    = store_addr(rslot_reg, idx_reg);
                    pend_next      = 1'b1;
                    pend_last_next = ((idx_reg + POS_W'(1)) == len_reg);
                    idx_next       = idx_reg + POS_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output buffer pointers
    always_comb
    begin
        obuf_wptr_next = push ? ~obuf_wptr_reg : obuf_wptr_reg;
        obuf_rptr_next = pop ? ~obuf_rptr_reg : obuf_rptr_reg;
        obuf_cnt_next  = obuf_cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rslot_reg     <= '0;
            wslot_reg     <= '0;
            nst_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            trunc_reg     <= 1'b0;
            framed_reg    <= 1'b0;
            period_reg    <= BYTE_PERIOD_RESET;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            obuf_wptr_reg <= 1'b0;
            obuf_rptr_reg <= 1'b0;
            obuf_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rslot_reg     <= rslot_next;
            wslot_reg     <= wslot_next;
            nst_reg       <= nst_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            trunc_reg     <= trunc_next;
            framed_reg    <= framed_next;
            period_reg    <= period_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            obuf_wptr_reg <= obuf_wptr_next;
            obuf_rptr_reg <= obuf_rptr_next;
            obuf_cnt_reg  <= obuf_cnt_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_kind_reg <= s_tuser;
            item_data_reg <= s_tdata[7:0];
            item_last_reg <= s_tlast;
            item_time_reg <= s_tdata[39:8];
        end
        len_reg       <= len_next;
        prod_reg      <= prod_next;
        pend_last_reg <= pend_last_next;
        if (push)
        begin
            obuf_reg[obuf_wptr_reg] <= push_word;
        end
    end

endmodule

// ===== tb/frltq_link_checker.sv =====
// Checker for the transmit queue: predicts every output word and compares it on arrival.
`timescale 1ns / 1ps

module frltq_link_checker
    import frltq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          words_pending,
    output logic [31:0] send_due_us
);

    // shadow copy of the queue
    logic [7:0]  slot_bytes [PORTION_COUNT][PORTION_BYTES];
    int unsigned slot_len [PORTION_COUNT];
    int unsigned rd_slot;
    int unsigned wr_slot;
    int unsigned fill_pos;
    logic [7:0]  frame_sum;
    logic        frame_trunc;
    logic        frame_marked;
    logic [15:0] period_us;
    logic [31:0] due_us;

    out_word_t   link_words [$];
    out_word_t   seen_word;

    function automatic void note_mismatch(string what, out_word_t want, out_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected kind=%0d byte=%02h last=%0d status=%0d, got kind=%0d byte=%02h last=%0d status=%0d",
                     $realtime, what, want.kind, want.data, want.last, want.status,
                     got.kind, got.data, got.last, got.status);
    endfunction

    // tick: send the oldest portion if one is waiting and its slot in time has come
    function automatic void emit_due_portion(logic [31:0] now_us);
        out_word_t w;
        int unsigned n;
        if (rd_slot == wr_slot || !(now_us > due_us))
            return;
        n = slot_len[rd_slot];
        due_us = now_us + 32'(n) * 32'(period_us);
        for (int unsigned i = 0; i < n; i++) begin
            w.kind   = OUT_BYTE;
            w.data   = slot_bytes[rd_slot][i];
            w.last   = (i + 1 == n);
            w.status = STAT_QUEUED;
            link_words.push_back(w);
        end
        rd_slot = (rd_slot + 1) % PORTION_COUNT;
    endfunction

    // message byte: fill the write slot, commit on the last byte
    function automatic void take_message_byte(logic [1:0] kind, logic [7:0] data, logic last);
        out_word_t w;
        int unsigned room;
        int unsigned n;
        if (fill_pos == 0) begin
            frame_marked = (kind == KIND_FRAMED);
            frame_sum    = '0;
            frame_trunc  = 1'b0;
            if (frame_marked) begin
                slot_bytes[wr_slot][0] = FRAME_START;
                fill_pos = 1;
            end
        end
        // framed portions keep the final byte for the checksum
        room = frame_marked ? PORTION_BYTES - 1 : PORTION_BYTES;
        if (fill_pos < room) begin
            slot_bytes[wr_slot][fill_pos] = data;
            frame_sum = frame_sum + data;
            fill_pos++;
        end
        else
            frame_trunc = 1'b1;
        if (!last)
            return;
        n = fill_pos;
        if (frame_marked) begin
            slot_bytes[wr_slot][n] = frame_sum;
            n++;
        end
        w.kind = OUT_STATUS;
        w.data = '0;
        w.last = 1'b0;
        if ((wr_slot + 1) % PORTION_COUNT == rd_slot)
            w.status = STAT_DROPPED;        // ring full: message discarded
        else begin
            slot_len[wr_slot] = n;
            wr_slot = (wr_slot + 1) % PORTION_COUNT;
            w.status = frame_trunc ? STAT_TRUNC : STAT_QUEUED;
        end
        fill_pos     = 0;
        frame_sum    = '0;
        frame_trunc  = 1'b0;
        frame_marked = 1'b0;
        link_words.push_back(w);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_words.delete();
            rd_slot       = 0;
            wr_slot       = 0;
            fill_pos      = 0;
            frame_sum     = '0;
            frame_trunc   = 1'b0;
            frame_marked  = 1'b0;
            period_us     = BYTE_PERIOD_RESET;
            due_us        = '0;
            mismatches    = 0;
            words_pending = 0;
            send_due_us   = '0;
        end
        else
        begin
            // outputs first: a word leaving now was caused by an earlier input
            if (m_tvalid && m_tready)
            begin
                seen_word.kind   = m_tuser[0];
                seen_word.data   = m_tdata[7:0];
                seen_word.last   = m_tlast;
                seen_word.status = m_tdata[9:8];
                if (link_words.size() == 0)
                    note_mismatch("unexpected word", '0, seen_word);
                else if (link_words[0] !== seen_word)
                    note_mismatch("wrong field", link_words.pop_front(), seen_word);
                else
                    void'(link_words.pop_front());
            end
            if (cfg_valid && cfg_ready)
                period_us = cfg_data;
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    KIND_TICK:             emit_due_portion(s_tdata[39:8]);
                    KIND_FRAMED, KIND_RAW: take_message_byte(s_tuser, s_tdata[7:0], s_tlast);
                    default:               ;
                endcase
            end
            words_pending = link_words.size();
            send_due_us   = due_us;
        end
    end

endmodule

// ===== tb/framed_rate_limited_tx_queue_top_tb.sv =====
// Testbench top: stimulus, handshake idling and verdict for the framed transmit queue.
`timescale 1ns / 1ps

module framed_rate_limited_tx_queue_top_tb
    import frltq_pkg::*;
;

    localparam int          LIMIT_CYCLES  = 1_000_000;
    localparam int          SETTLE_CYCLES = 40;     // lets the longest due tick finish
    localparam logic [1:0]  KIND_SPARE    = 2'd3;   // unused kind, must be ignored

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          mismatches;
    int          words_pending;
    logic [31:0] send_due_us;     // predicted next send time, used to aim ticks

    int          cycle_count;
    int          words_sent;
    bit          idle_on;

    framed_rate_limited_tx_queue_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    frltq_link_checker link_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .send_due_us   (send_due_us)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL framed_rate_limited_tx_queue_top");
            $finish;
        end
    end

    // receiver: random stall bursts while idling is enabled
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 11) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                m_tready = 1'b1;
            end
        end
    end

    // One input word. Called and returns at a falling edge; valid stays high
    // afterwards, so back-to-back words do not drop it between them.
    task automatic put_word(logic [1:0] kind, logic [7:0] data, logic last, logic [31:0] t_us);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {t_us, data};
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (kind != KIND_SPARE)
            words_sent++;
    endtask

    // Tick aimed around the predicted send time: mostly due, sometimes exactly
    // on it or just short of it, sometimes anywhere.
    task automatic send_tick();
        logic [31:0] t_us;
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            t_us = send_due_us + 32'd1 + 32'($urandom_range(0, 2000));
        else if (r < 75)
            t_us = send_due_us;
        else if (r < 85)
            t_us = send_due_us - 32'($urandom_range(1, 50));
        else
            t_us = $urandom;
        put_word(KIND_TICK, 8'($urandom), 1'($urandom), t_us);
    endtask

    // Mostly short messages; a few run past capacity to force truncation.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 6);
        else if (r < 9)
            return $urandom_range(7, 29);
        return $urandom_range(30, 40);
    endfunction

    // Message of n bytes. With mixed set, later bytes carry either kind;
    // ticks and spare words may land in the middle.
    task automatic send_message(bit framed, int n, bit mixed);
        logic [1:0] kind;
        for (int i = 0; i < n; i++)
        begin
            kind = framed ? KIND_FRAMED : KIND_RAW;
            if (i > 0 && mixed)
                kind = $urandom_range(0, 1) ? KIND_FRAMED : KIND_RAW;
            if (i > 0 && $urandom_range(0, 15) == 0)
                send_tick();
            if (i > 0 && $urandom_range(0, 30) == 0)
                put_word(KIND_SPARE, 8'($urandom), 1'($urandom), $urandom);
            put_word(kind, 8'($urandom), i == n - 1, $urandom);
        end
    endtask

    // Stop sending until every predicted word is out, then let the block settle.
    task automatic drain();
        s_tvalid = 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_period(logic [15:0] period);
        cfg_valid = 1'b1;
        cfg_data  = period;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(int n_words, bit pause_midway);
        int start;
        int r;
        bit paused;
        start  = words_sent;
        paused = !pause_midway;
        while (words_sent - start < n_words)
        begin
            if (!paused && words_sent - start >= n_words / 2)
            begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 50)
                send_message($urandom_range(0, 1), pick_length(), $urandom_range(0, 6) == 0);
            else if (r < 85)
                send_tick();
            else if (r < 90)
                // burst of short messages to run the ring full
                repeat (8) send_message($urandom_range(0, 1), $urandom_range(1, 3), 1'b0);
            else if (r < 95)
                repeat ($urandom_range(2, 10)) send_tick();
            else
                put_word(KIND_SPARE, 8'($urandom), 1'($urandom), $urandom);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_FRAMED;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        idle_on     = 1'b1;
        cycle_count = 0;
        words_sent  = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, reset byte period
        put_word(KIND_TICK, 8'h00, 1'b0, 32'd0);                  // empty queue
        put_word(KIND_FRAMED, 8'hFF, 1'b1, 32'd0);                // one-byte framed
        put_word(KIND_RAW, 8'h00, 1'b0, 32'hFFFF_FFFF);           // raw, two bytes
        put_word(KIND_RAW, 8'h80, 1'b1, 32'd0);
        put_word(KIND_FRAMED, 8'h01, 1'b0, 32'd0);                // framing set by first byte
        put_word(KIND_RAW, 8'h7F, 1'b1, 32'd0);
        put_word(KIND_SPARE, 8'hA5, 1'b1, 32'h5A5A_5A5A);         // ignored
        put_word(KIND_TICK, 8'h00, 1'b0, 32'd0);                  // not later than due time
        put_word(KIND_TICK, 8'h00, 1'b0, 32'hFFFF_FFF0);          // due, send time wraps
        put_word(KIND_TICK, 8'h00, 1'b0, send_due_us);            // equal: not due
        put_word(KIND_TICK, 8'h00, 1'b0, send_due_us + 32'd1);    // one past: due
        put_word(KIND_TICK, 8'h00, 1'b0, 32'hFFFF_FFFF);          // top of range
        // seven portions fill the ring, the eighth message is dropped
        for (int i = 0; i < 8; i++)
            put_word(KIND_RAW, 8'(i * 37), 1'b1, 32'd0);

        run_random(70, 1'b1);

        drain();
        write_period(16'd1);
        run_random(70, 1'b0);

        drain();
        write_period(16'hFFFF);
        run_random(70, 1'b0);

        // closing stretch: no idling on either side
        drain();
        write_period(16'($urandom_range(2, 65534)));
        idle_on = 1'b0;
        run_random(80, 1'b0);

        drain();
        if (mismatches == 0 && words_pending == 0)
            $display("PASS framed_rate_limited_tx_queue_top");
        else
            $display("FAIL framed_rate_limited_tx_queue_top");
        $finish;
    end

endmodule
